FILE: hdl/psm_pkg.sv
// shared types and codes for the packed slot map
// no dependencies; used by every module of the block
package psm_pkg;

  localparam int ENTITY_W  = 10;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_O_W  = 8;
  localparam int LIVE_O_W  = 9;
  localparam int IDX_MAX_W = 16;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // write commands for the entity-indexed stores
  typedef struct packed {
    logic                 pres_we;
    logic                 pres_val;
    logic [IDX_MAX_W-1:0] pres_idx;
    logic                 slot_we;
    logic [IDX_MAX_W-1:0] slot_idx;
    logic [IDX_MAX_W-1:0] slot_val;
  } map_wr_t;

  // write command for the dense entity array
  typedef struct packed {
    logic                 we;
    logic [IDX_MAX_W-1:0] idx;
    logic [ENTITY_W-1:0]  data;
  } dense_wr_t;

endpackage

FILE: hdl/psm_map.sv
// entity-indexed stores: presence bit and slot of each entity
// depends on psm_pkg; one shared registered read, independent write ports
module psm_map #(
  parameter int DEPTH  = 1024,
  parameter int IDX_W  = 10,
  parameter int SLOT_W = 8
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  input  psm_pkg::map_wr_t     wr,
  output logic                 pres_q,
  output logic [SLOT_W-1:0]    slot_q
);

  logic              pres_mem [DEPTH];
  logic [SLOT_W-1:0] slot_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.pres_we) begin
      pres_mem[wr.pres_idx[IDX_W-1:0]] <= wr.pres_val;
    end
    if (wr.slot_we) begin
      slot_mem[wr.slot_idx[IDX_W-1:0]] <= wr.slot_val[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pres_q <= pres_mem[rd_idx];
      slot_q <= slot_mem[rd_idx];
    end
  end

endmodule

FILE: hdl/psm_dense.sv
// dense array of entity ids indexed by slot
// depends on psm_pkg; one write port and one registered read port
module psm_dense #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_idx,
  input  psm_pkg::dense_wr_t            wr,
  output logic [psm_pkg::ENTITY_W-1:0]  rd_q
);

  logic [psm_pkg::ENTITY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

endmodule

FILE: hdl/packed_slot_map_swap_remove.sv
// Packed slot map with swap-remove: keeps a dense array of entity ids, a map
// from entity to slot and a live count. In the accept cycle the entity map and
// the last dense entry are read; in S_EXEC the result is decided, a successful
// create or remove writes the stores back, and the result is registered once
// the output register is free. A new word is taken only after the last one is
// done. After reset the presence store is swept clear, one entry a cycle, over
// all MAX_ENTITIES entries (1024 by default); s_tready stays low meanwhile.
// depends on psm_pkg, psm_map and psm_dense
module packed_slot_map_swap_remove #(
  parameter int MAX_ENTITIES = 1024,
  parameter int MAX_SLOTS    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] entity, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] slot, [15:8] moved_from_slot, [24:16] live_entries
  output logic [3:0]  m_tuser    // [2:0] status, [3] moved
);

  localparam int EW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam logic [EW-1:0] CLR_LAST = EW'(MAX_ENTITIES - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [EW-1:0] clr_idx;
  logic [CW-1:0] live_count, live_count_next;
  logic [psm_pkg::OP_W-1:0]     op_q;
  logic [psm_pkg::ENTITY_W-1:0] ent_q;

  logic [psm_pkg::STATUS_W-1:0] status_r, status_next;
  logic [psm_pkg::SLOT_O_W-1:0] slot_r, slot_next;
  logic                         moved_r, moved_next;
  logic [psm_pkg::SLOT_O_W-1:0] from_r, from_next;
  logic [psm_pkg::LIVE_O_W-1:0] live_r, live_next;

  logic accept, finish;
  logic [psm_pkg::IDX_MAX_W-1:0] ent_in_wide;
  logic [CW-1:0] live_m1;

  psm_pkg::map_wr_t   map_wr;
  psm_pkg::dense_wr_t dense_wr;
  logic               pres_q;
  logic [SW-1:0]      slot_q;
  logic [psm_pkg::ENTITY_W-1:0] dense_q;

  // decode helpers
  logic [16:0] ent_wide, mov_wide;
  logic        in_range, here, mov_in_range, moving;
  logic [CW-1:0] slot_ext;
  logic [31:0]   slot_res, from_res, live_res;

  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign finish      = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign ent_in_wide = psm_pkg::IDX_MAX_W'(s_tdata[psm_pkg::ENTITY_W-1:0]);
  assign live_m1     = live_count - CW'(1);

  psm_map #(
    .DEPTH  (MAX_ENTITIES),
    .IDX_W  (EW),
    .SLOT_W (SW)
  ) u_map (
    .clk    (clk),
    .rd_en  (accept),
    .rd_idx (ent_in_wide[EW-1:0]),
    .wr     (map_wr),
    .pres_q (pres_q),
    .slot_q (slot_q)
  );

  psm_dense #(
    .DEPTH (MAX_SLOTS),
    .IDX_W (SW)
  ) u_dense (
    .clk    (clk),
    .rd_en  (accept),
    .rd_idx (live_m1[SW-1:0]),
    .wr     (dense_wr),
    .rd_q   (dense_q)
  );

  always_comb begin
    ent_wide     = 17'(ent_q);
    mov_wide     = 17'(dense_q);
    in_range     = ent_wide < 17'(MAX_ENTITIES);
    here         = in_range && pres_q;
    mov_in_range = mov_wide < 17'(MAX_ENTITIES);
    slot_ext     = CW'(slot_q);
    moving       = slot_ext < live_m1;

    map_wr          = '0;
    dense_wr        = '0;
    live_count_next = live_count;
    status_next     = psm_pkg::ST_OK;
    slot_res        = '0;
    moved_next      = 1'b0;
    from_res        = '0;
    state_next      = state;

    case (state)
      S_CLEAR: begin
        map_wr.pres_we  = 1'b1;
        map_wr.pres_val = 1'b0;
        map_wr.pres_idx = psm_pkg::IDX_MAX_W'(clr_idx);
        if (clr_idx == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          psm_pkg::OP_CREATE: begin
            if (ent_q == '0 || !in_range) begin
              status_next = psm_pkg::ST_INVALID;
            end else if (here) begin
              status_next = psm_pkg::ST_DUPLICATE;
            end else if (live_count == CNT_FULL) begin
              status_next = psm_pkg::ST_FULL;
            end else begin
              slot_res        = 32'(live_count);
              live_count_next = live_count + CW'(1);
              map_wr.pres_we  = finish;
              map_wr.pres_val = 1'b1;
              map_wr.pres_idx = psm_pkg::IDX_MAX_W'(ent_q);
              map_wr.slot_we  = finish;
              map_wr.slot_idx = psm_pkg::IDX_MAX_W'(ent_q);
              map_wr.slot_val = psm_pkg::IDX_MAX_W'(live_count[SW-1:0]);
              dense_wr.we     = finish;
              dense_wr.idx    = psm_pkg::IDX_MAX_W'(live_count[SW-1:0]);
              dense_wr.data   = ent_q;
            end
          end
          psm_pkg::OP_REMOVE: begin
            if (!here || live_count == '0) begin
              status_next = psm_pkg::ST_ABSENT;
            end else begin
              slot_res        = 32'(slot_q);
              live_count_next = live_m1;
              map_wr.pres_we  = finish;
              map_wr.pres_val = 1'b0;
              map_wr.pres_idx = psm_pkg::IDX_MAX_W'(ent_q);
              // last entry fills the hole left by the removed one
              if (moving) begin
                moved_next      = 1'b1;
                from_res        = 32'(live_m1);
                dense_wr.we     = finish;
                dense_wr.idx    = psm_pkg::IDX_MAX_W'(slot_q);
                dense_wr.data   = dense_q;
                map_wr.slot_we  = finish && mov_in_range;
                map_wr.slot_idx = psm_pkg::IDX_MAX_W'(dense_q);
                map_wr.slot_val = psm_pkg::IDX_MAX_W'(slot_q);
              end
            end
          end
          default: begin
            // lookup, and the unused code behaves the same
            if (!here) begin
              status_next = psm_pkg::ST_ABSENT;
            end else begin
              slot_res = 32'(slot_q);
            end
          end
        endcase
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    live_res   = 32'(live_count_next);
    slot_next  = slot_res[psm_pkg::SLOT_O_W-1:0];
    from_next  = from_res[psm_pkg::SLOT_O_W-1:0];
    live_next  = live_res[psm_pkg::LIVE_O_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      live_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + EW'(1);
      end
      if (finish) begin
        live_count <= live_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= s_tuser;
      ent_q <= s_tdata[psm_pkg::ENTITY_W-1:0];
    end
    if (finish) begin
      status_r <= status_next;
      slot_r   <= slot_next;
      moved_r  <= moved_next;
      from_r   <= from_next;
      live_r   <= live_next;
    end
  end

  assign m_tdata = {7'd0, live_r, from_r, slot_r};
  assign m_tuser = {moved_r, status_r};

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for packed_slot_map_swap_remove: directed and random
// create, lookup and remove words against an in-bench slot map predictor
// depends on psm_pkg and the block's rtl
module tb;

  localparam logic [psm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_ENTITIES = 1024;
  localparam int NUM_SLOTS = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic [psm_pkg::STATUS_W-1:0] status;
    logic [psm_pkg::SLOT_O_W-1:0] slot;
    logic                         moved;
    logic [psm_pkg::SLOT_O_W-1:0] moved_from;
    logic [psm_pkg::LIVE_O_W-1:0] live;
  } map_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [9:0] entity, rest zero
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [7:0] slot, [15:8] moved_from_slot, [24:16] live_entries
  logic [3:0]  m_tuser;        // [2:0] status, [3] moved

  // shadow copy of the block's stores
  bit                              present_map [NUM_ENTITIES];
  logic [psm_pkg::SLOT_O_W-1:0]    slot_map [NUM_ENTITIES];
  logic [psm_pkg::ENTITY_W-1:0]    dense_ents [NUM_SLOTS];
  logic [psm_pkg::LIVE_O_W-1:0]    live_cnt;

  // expected words in order, written by the sender and read by the checker
  map_result_t exp_fifo [EXP_DEPTH];
  int          exp_pushed = 0;
  int          exp_popped = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  bit          no_gaps = 1'b0;

  packed_slot_map_swap_remove uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  // apply one operation to the shadow map and return what the block must answer
  function automatic map_result_t apply_map_op(input logic [psm_pkg::OP_W-1:0] op,
                                               input logic [psm_pkg::ENTITY_W-1:0] ent);
    map_result_t r;
    logic [psm_pkg::LIVE_O_W-1:0] last;
    logic [psm_pkg::SLOT_O_W-1:0] s;
    logic [psm_pkg::ENTITY_W-1:0] m;
    bit here;
    r = '0;
    here = present_map[ent];
    if (op == psm_pkg::OP_CREATE) begin
      if (ent == '0) r.status = psm_pkg::ST_INVALID;
      else if (here) r.status = psm_pkg::ST_DUPLICATE;
      else if (live_cnt >= psm_pkg::LIVE_O_W'(NUM_SLOTS)) r.status = psm_pkg::ST_FULL;
      else begin
        s = live_cnt[psm_pkg::SLOT_O_W-1:0];
        slot_map[ent] = s;
        dense_ents[s] = ent;
        present_map[ent] = 1'b1;
        live_cnt = live_cnt + psm_pkg::LIVE_O_W'(1);
        r.status = psm_pkg::ST_OK;
        r.slot = s;
      end
    end else if (op == psm_pkg::OP_REMOVE) begin
      if (!here || live_cnt == '0) r.status = psm_pkg::ST_ABSENT;
      else begin
        s = slot_map[ent];
        last = live_cnt - psm_pkg::LIVE_O_W'(1);
        // swap the last live entry into the hole
        if (psm_pkg::LIVE_O_W'(s) < last) begin
          m = dense_ents[last[psm_pkg::SLOT_O_W-1:0]];
          dense_ents[s] = m;
          slot_map[m] = s;
          r.moved = 1'b1;
          r.moved_from = last[psm_pkg::SLOT_O_W-1:0];
        end
        present_map[ent] = 1'b0;
        live_cnt = last;
        r.status = psm_pkg::ST_OK;
        r.slot = s;
      end
    end else begin
      // lookup, and the unused code behaves as lookup
      if (!here) r.status = psm_pkg::ST_ABSENT;
      else begin
        r.status = psm_pkg::ST_OK;
        r.slot = slot_map[ent];
      end
    end
    r.live = live_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t got;
    map_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser[2:0];
      got.moved = m_tuser[3];
      got.slot = m_tdata[7:0];
      got.moved_from = m_tdata[15:8];
      got.live = m_tdata[24:16];
      if (exp_pushed == exp_popped) begin
        errors++;
        $display("%0t: unexpected word status=%0d slot=%0d moved=%0d from=%0d live=%0d",
                 $time, got.status, got.slot, got.moved, got.moved_from, got.live);
      end else begin
        want = exp_fifo[exp_popped[5:0]];
        exp_popped++;
        if (got.status !== want.status || got.slot !== want.slot ||
            got.moved !== want.moved || got.moved_from !== want.moved_from ||
            got.live !== want.live) begin
          errors++;
          $display("%0t: mismatch expected status=%0d slot=%0d moved=%0d from=%0d live=%0d",
                   $time, want.status, want.slot, want.moved, want.moved_from, want.live);
          $display("%0t:          actual   status=%0d slot=%0d moved=%0d from=%0d live=%0d",
                   $time, got.status, got.slot, got.moved, got.moved_from, got.live);
        end
      end
    end
  end

  task automatic send_word(input logic [psm_pkg::OP_W-1:0] op,
                           input logic [psm_pkg::ENTITY_W-1:0] ent);
    while (!no_gaps && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, ent};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_fifo[exp_pushed[5:0]] = apply_map_op(op, ent);
    exp_pushed++;
  endtask

  // hold the sender off until every expected word is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (exp_pushed != exp_popped) @(posedge clk);
  endtask

  function automatic logic [psm_pkg::ENTITY_W-1:0] pick_live();
    logic [psm_pkg::SLOT_O_W-1:0] idx;
    idx = psm_pkg::SLOT_O_W'($urandom_range(0, int'(live_cnt) - 1));
    return dense_ents[idx];
  endfunction

  task automatic test_corner_ops();
    send_word(psm_pkg::OP_CREATE, 10'd0);
    send_word(psm_pkg::OP_LOOKUP, 10'd0);
    send_word(psm_pkg::OP_REMOVE, 10'd0);
    send_word(psm_pkg::OP_CREATE, 10'd1023);
    send_word(psm_pkg::OP_CREATE, 10'd1);
    send_word(psm_pkg::OP_CREATE, 10'd1023);
    send_word(psm_pkg::OP_LOOKUP, 10'd1023);
    send_word(OP_UNUSED, 10'd1);
    send_word(OP_UNUSED, 10'd700);
    send_word(psm_pkg::OP_LOOKUP, 10'd512);
    send_word(psm_pkg::OP_REMOVE, 10'd512);
    send_word(psm_pkg::OP_CREATE, 10'd682);
    send_word(psm_pkg::OP_CREATE, 10'd341);
    send_word(psm_pkg::OP_REMOVE, 10'd1023);
    send_word(psm_pkg::OP_LOOKUP, 10'd341);
    send_word(psm_pkg::OP_REMOVE, 10'd341);
    send_word(psm_pkg::OP_REMOVE, 10'd341);
    send_word(psm_pkg::OP_REMOVE, 10'd682);
    send_word(psm_pkg::OP_REMOVE, 10'd1);
    send_word(psm_pkg::OP_LOOKUP, 10'd1);
    wait_drained();
  endtask

  task automatic test_full_store();
    int e;
    for (e = 2; e < 2 + NUM_SLOTS; e++) begin
      send_word(psm_pkg::OP_CREATE, psm_pkg::ENTITY_W'(e));
    end
    send_word(psm_pkg::OP_CREATE, 10'd900);
    send_word(psm_pkg::OP_CREATE, 10'd2);
    send_word(psm_pkg::OP_CREATE, 10'd0);
    send_word(psm_pkg::OP_LOOKUP, 10'd257);
    send_word(psm_pkg::OP_REMOVE, 10'd2);
    while (live_cnt != '0) send_word(psm_pkg::OP_REMOVE, pick_live());
    wait_drained();
  endtask

  task automatic test_random_ops();
    int i;
    int pick;
    bit grow;
    logic [psm_pkg::OP_W-1:0] op;
    logic [psm_pkg::ENTITY_W-1:0] ent;
    grow = 1'b1;
    for (i = 0; i < 1400; i++) begin
      no_gaps = (i >= 500 && i < 800);
      if (grow && live_cnt == psm_pkg::LIVE_O_W'(NUM_SLOTS) && $urandom_range(0, 7) == 0)
        grow = 1'b0;
      if (!grow && live_cnt == '0) grow = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        op = psm_pkg::OP_W'($urandom_range(0, 3));
        ent = (pick < 2) ? 10'd0 : psm_pkg::ENTITY_W'($urandom_range(0, NUM_ENTITIES - 1));
      end else if (pick < (grow ? 75 : 20)) begin
        op = psm_pkg::OP_CREATE;
        ent = psm_pkg::ENTITY_W'($urandom_range(1, NUM_ENTITIES - 1));
      end else if (live_cnt == '0) begin
        op = psm_pkg::OP_W'($urandom_range(0, 3));
        ent = psm_pkg::ENTITY_W'($urandom_range(0, NUM_ENTITIES - 1));
      end else begin
        op = (pick < (grow ? 88 : 40)) ? psm_pkg::OP_LOOKUP : psm_pkg::OP_REMOVE;
        ent = pick_live();
      end
      send_word(op, ent);
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    live_cnt = '0;
    for (int k = 0; k < NUM_ENTITIES; k++) present_map[k] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_corner_ops();
    test_full_store();
    test_random_ops();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/psm_pkg.sv
hdl/psm_map.sv
hdl/psm_dense.sv
hdl/packed_slot_map_swap_remove.sv
bench/tb.sv
